// ===== rtl/sobs_pkg.sv =====
// Shared types and constants of the shift-or byte scanner.
package sobs_pkg;

  // Field widths of the item channels
  localparam int unsigned ModeW  = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaskW  = 32;
  localparam int unsigned CountW = 32;

  // Class table geometry
  localparam int unsigned TableDepth = 256;

  // Configuration port geometry
  localparam int unsigned LenW      = 6;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 6;
  localparam logic [LenW-1:0] LenReset = LenW'(1);

  // Item operation, encoded as the mode field
  typedef enum logic [ModeW-1:0] {
    OP_LOAD    = 2'd0,
    OP_SCAN    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  localparam int unsigned OpW = $bits(op_e);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_LENGTH = 1'b0,
    CFG_REVERSE_SCAN   = 1'b1
  } cfg_idx_e;

  // Configuration as seen by the scan engine
  typedef struct packed {
    logic [LenW-1:0] pattern_length;
    logic            reverse_scan;
  } cfg_t;

endpackage

// ===== rtl/sobs_if.sv =====
// Valid/ready channel interfaces for scanner input items and result items.
interface sobs_in_if;
  logic                          valid;
  logic                          ready;
  logic [sobs_pkg::ModeW-1:0]    mode;
  logic [sobs_pkg::ByteW-1:0]    byte_value;
  logic [sobs_pkg::MaskW-1:0]    mask_word;

  modport source (output valid, output mode, output byte_value, output mask_word,
                  input ready);
  modport sink   (input valid, input mode, input byte_value, input mask_word,
                  output ready);
endinterface

interface sobs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [sobs_pkg::CountW-1:0]   scanned_count;

  modport source (output valid, output hit, output scanned_count, input ready);
  modport sink   (input valid, input hit, input scanned_count, output ready);
endinterface

// ===== rtl/sobs_front.sv =====
// Front end: accepts items, owns the class table, reads the entry for scan bytes.
module sobs_front #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sobs_in_if.sink               in_i,
  input  logic                  push_ready_i,
  output logic                  push_valid_o,
  output sobs_pkg::op_e         push_op_o,
  output logic [WORD_BITS-1:0]  push_entry_o
);

  logic                 accept;
  logic                 stage_valid_q;
  sobs_pkg::op_e        stage_op_q;
  logic [WORD_BITS-1:0] entry_q;
  sobs_pkg::op_e        in_op;

  logic [WORD_BITS-1:0] table_mem [sobs_pkg::TableDepth];

  // Take a new item when the stage is empty or drains this cycle
  assign in_i.ready = !stage_valid_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign in_op      = sobs_pkg::op_e'(in_i.mode);

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      stage_op_q    <= sobs_pkg::OP_NOP;
    end else begin
      stage_valid_q <= accept || (stage_valid_q && !push_ready_i);
      if (accept) begin
        stage_op_q <= in_op;
      end
    end
  end

  // Class table: write on load, registered read on scan
  always_ff @(posedge clk_i) begin
    if (accept && in_op == sobs_pkg::OP_LOAD) begin
      table_mem[in_i.byte_value] <= WORD_BITS'(in_i.mask_word);
    end
    if (accept && in_op == sobs_pkg::OP_SCAN) begin
      entry_q <= table_mem[in_i.byte_value];
    end
  end

  assign push_valid_o = stage_valid_q;
  assign push_op_o    = stage_op_q;
  assign push_entry_o = entry_q;

endmodule

// ===== rtl/sobs_fifo.sv =====
// Two-entry queue that decouples the front end from the scan engine.
module sobs_fifo #(
  parameter int unsigned DATA_W = 34
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = 1;
  localparam int unsigned CntW  = 2;

  logic [DATA_W-1:0] slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              push;
  logic              pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Store queued items
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/sobs_back.sv =====
// Scan engine: updates the match vector and byte count, registers the result.
module sobs_back #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sobs_pkg::cfg_t        cfg_i,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  sobs_pkg::op_e         pop_op_i,
  input  logic [WORD_BITS-1:0]  pop_entry_i,
  sobs_out_if.source            out_o
);

  localparam int unsigned IdxW = $clog2(WORD_BITS);
  localparam int unsigned LenW = sobs_pkg::LenW;

  logic [WORD_BITS-1:0]           match_q, match_d;
  logic [sobs_pkg::CountW-1:0]    count_q, count_d;
  logic                           out_valid_q;
  logic                           hit_q, hit_d;
  logic [sobs_pkg::CountW-1:0]    res_count_q;
  logic                           pop;
  logic [LenW-1:0]                eff_len;
  logic [IdxW-1:0]                test_idx;
  logic [WORD_BITS-1:0]           shifted;

  assign pop         = pop_valid_i && (!out_valid_q || out_o.ready);
  assign pop_ready_o = !out_valid_q || out_o.ready;

  // Clamp the pattern length to 1..WORD_BITS
  always_comb begin
    eff_len = cfg_i.pattern_length;
    if (eff_len == '0) begin
      eff_len = LenW'(1);
    end else if ({1'b0, eff_len} > (LenW + 1)'(WORD_BITS)) begin
      eff_len = LenW'(WORD_BITS);
    end
    test_idx = IdxW'(eff_len - LenW'(1));
  end

  // Next match vector, counter and hit flag
  always_comb begin
    match_d = match_q;
    count_d = count_q;
    hit_d   = 1'b0;
    shifted = cfg_i.reverse_scan ? (match_q >> 1) : (match_q << 1);
    case (pop_op_i)
      sobs_pkg::OP_SCAN: begin
        match_d = shifted | pop_entry_i;
        count_d = count_q + sobs_pkg::CountW'(1);
        hit_d   = cfg_i.reverse_scan ? !match_d[0] : !match_d[test_idx];
      end
      sobs_pkg::OP_RESTART: begin
        match_d = cfg_i.reverse_scan ? ~({WORD_BITS{1'b1}} << eff_len)
                                     : {WORD_BITS{1'b1}};
        count_d = '0;
      end
      default: begin
        match_d = match_q;
      end
    endcase
  end

  // Commit state and present the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q     <= {WORD_BITS{1'b1}};
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        match_q     <= match_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      hit_q       <= hit_d;
      res_count_q <= count_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.hit           = hit_q;
  assign out_o.scanned_count = res_count_q;

endmodule

// ===== rtl/shift_or_byte_scanner_unit.sv =====
// Shift-or byte scanner: top level with configuration registers and assertions.
//
// Usage: items arrive on in_i (valid/ready). Mode 0 loads mask_word into the
// class table at index byte_value, mode 1 scans byte_value, mode 2 restarts
// the match vector and byte counter. Every item yields exactly one result on
// out_o: hit (scan bytes only) and the byte count since the last restart.
// Configuration (pattern length, reverse order) is written through cfg_we_i,
// cfg_idx_i and cfg_data_i while no item is in flight; it applies from the
// next item on.
// A result passes the table read stage, the queue and the result register
// before it is valid on out_o. Throughput: one item per cycle while out_o is
// ready, set by the single-ported class table read in the front stage and the
// shift/OR update of the match vector.
// Reset: match vector all ones, count zero, pattern length 1, forward order.
// The class table is not cleared; a scan of an entry never loaded gives an
// undefined hit.
// Stall: when out_o is not ready the result register holds, the two-entry
// queue and the front stage fill and then in_i.ready drops until results drain.
module shift_or_byte_scanner_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sobs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sobs_pkg::CfgDataW-1:0]    cfg_data_i,
  sobs_in_if.sink                          in_i,
  sobs_out_if.source                       out_o
);

  localparam int unsigned QueueW = sobs_pkg::OpW + WORD_BITS;

  sobs_pkg::cfg_t       cfg_q;
  logic                 front_valid;
  logic                 front_ready;
  sobs_pkg::op_e        front_op;
  logic [WORD_BITS-1:0] front_entry;
  logic                 q_valid;
  logic                 q_ready;
  logic [QueueW-1:0]    q_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length <= sobs_pkg::LenReset;
      cfg_q.reverse_scan   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (sobs_pkg::cfg_idx_e'(cfg_idx_i))
        sobs_pkg::CFG_PATTERN_LENGTH: begin
          cfg_q.pattern_length <= cfg_data_i[sobs_pkg::LenW-1:0];
        end
        sobs_pkg::CFG_REVERSE_SCAN: begin
          cfg_q.reverse_scan <= cfg_data_i[0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  sobs_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_ready_i (front_ready),
    .push_valid_o (front_valid),
    .push_op_o    (front_op),
    .push_entry_o (front_entry)
  );

  sobs_fifo #(.DATA_W(QueueW)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  ({front_op, front_entry}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  sobs_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (q_valid),
    .pop_ready_o (q_ready),
    .pop_op_i    (sobs_pkg::op_e'(q_data[QueueW-1:WORD_BITS])),
    .pop_entry_i (q_data[WORD_BITS-1:0]),
    .out_o       (out_o)
  );

`ifndef NO_ASSERTIONS
  // An item leaving the queue always shows up as a result next cycle
  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && q_ready |=> out_o.valid)
    else $error("queued item produced no result");

  // With nothing in flight no result may appear
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !front_valid && !q_valid && !out_o.valid |=> !out_o.valid)
    else $error("result appeared with no item in flight");

  // Input backpressure only when front stage and queue are both full
  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> front_valid && !front_ready)
    else $error("input stalled with room in front stage or queue");
`endif

endmodule

// ===== tb/shift_or_byte_scanner_unit_tb.sv =====
// Self-checking testbench of the shift-or byte scanner: directed table, then random pattern traffic.
module shift_or_byte_scanner_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sobs_pkg::*;

  localparam int unsigned WordBits     = 32;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseItems   = 166;
  localparam int unsigned PressurePh   = 6;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned AlphaSize    = 4;

  typedef struct packed {
    logic              hit;
    logic [CountW-1:0] scanned_count;
  } scan_res_t;

  // Result fixed by hand for a directed row; typed clear means use the prediction
  typedef struct packed {
    bit                typed;
    logic              hit;
    logic [CountW-1:0] cnt;
  } fixed_res_t;

  typedef struct {
    bit                  is_cfg;
    cfg_idx_e            reg_idx;
    logic [CfgDataW-1:0] reg_data;
    op_e                 op;
    logic [ByteW-1:0]    b;
    logic [MaskW-1:0]    w;
    bit                  typed;
    logic                hit;
    logic [CountW-1:0]   cnt;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  sobs_in_if  in_if ();
  sobs_out_if out_if ();

  shift_or_byte_scanner_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Predicted scanner state
  logic [WordBits-1:0] class_tbl [TableDepth];
  logic [WordBits-1:0] match_vec;
  logic [CountW-1:0]   byte_cnt;
  logic [LenW-1:0]     len_reg;
  logic                rev_reg;

  scan_res_t        pending_res_q [$];
  fixed_res_t       typed_res_q [$];
  stim_row_t        dir_q [$];
  logic [ByteW-1:0] loaded_q [$];

  // Stimulus-side view of the configuration
  logic [LenW-1:0] gen_len;
  logic            gen_rev;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_gen;
  int unsigned quiet_cycles = 0;
  int          err_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_len(logic [LenW-1:0] len);
    if (len == 0) return 1;
    if (len > WordBits) return WordBits;
    return len;
  endfunction

  function automatic logic [WordBits-1:0] low_ones(int unsigned m);
    return {WordBits{1'b1}} >> (WordBits - m);
  endfunction

  // Advance the predicted state by one item and return its result
  function automatic scan_res_t shift_or_step(op_e op, logic [ByteW-1:0] b,
                                              logic [MaskW-1:0] w);
    int unsigned m;
    scan_res_t   r;
    m     = eff_len(len_reg);
    r.hit = 1'b0;
    case (op)
      OP_LOAD: begin
        class_tbl[b] = w;
      end
      OP_SCAN: begin
        byte_cnt = byte_cnt + 1'b1;
        if (rev_reg) begin
          match_vec = (match_vec >> 1) | class_tbl[b];
          r.hit     = ~match_vec[0];
        end else begin
          match_vec = (match_vec << 1) | class_tbl[b];
          r.hit     = ~match_vec[m-1];
        end
      end
      OP_RESTART: begin
        match_vec = rev_reg ? low_ones(m) : {WordBits{1'b1}};
        byte_cnt  = '0;
      end
      default: ;
    endcase
    r.scanned_count = byte_cnt;
    return r;
  endfunction

  // Check results, track register writes, predict accepted items
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    scan_res_t  want;
    scan_res_t  got;
    fixed_res_t fx;
    if (!rst_ni) begin
      match_vec = {WordBits{1'b1}};
      byte_cnt  = '0;
      len_reg   = LenReset;
      rev_reg   = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.hit           = out_if.hit;
        got.scanned_count = out_if.scanned_count;
        if (pending_res_q.size() == 0) begin
          err_cnt++;
          $error("scanned_count: no result expected, got %0d", got.scanned_count);
        end else begin
          want = pending_res_q.pop_front();
          if (got.hit !== want.hit) begin
            err_cnt++;
            $error("hit: expected %0b, got %0b", want.hit, got.hit);
          end
          if (got.scanned_count !== want.scanned_count) begin
            err_cnt++;
            $error("scanned_count: expected %0d, got %0d",
                   want.scanned_count, got.scanned_count);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PATTERN_LENGTH: len_reg = cfg_data_i[LenW-1:0];
          CFG_REVERSE_SCAN:   rev_reg = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        want = shift_or_step(op_e'(in_if.mode), in_if.byte_value, in_if.mask_word);
        fx   = typed_res_q.pop_front();
        if (fx.typed) begin
          want.hit           = fx.hit;
          want.scanned_count = fx.cnt;
        end
        pending_res_q.push_back(want);
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("shift_or_byte_scanner_unit_tb: errors");
      $finish;
    end
  end

  // Drive out_o ready: random stalls, or a long hold when requested
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_gen != hold_seen) begin
        hold_seen = hold_gen;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item from a falling edge and return at the falling edge after its transfer
  task automatic send_item(op_e op, logic [ByteW-1:0] b, logic [MaskW-1:0] w,
                           bit typed = 1'b0, logic hit = 1'b0,
                           logic [CountW-1:0] cnt = '0);
    fixed_res_t fx;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    fx.typed = typed;
    fx.hit   = hit;
    fx.cnt   = cnt;
    typed_res_q.push_back(fx);
    in_if.valid      = 1'b1;
    in_if.mode       = op;
    in_if.byte_value = b;
    in_if.mask_word  = w;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    if (op == OP_LOAD) loaded_q.push_back(b);
  endtask

  // Write a register once all results are out and the pipeline has settled
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    in_if.valid = 1'b0;
    while (pending_res_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_PATTERN_LENGTH) begin
      gen_len = data[LenW-1:0];
    end else begin
      gen_rev = data[0];
    end
  endtask

  function automatic void add_op(op_e op, logic [ByteW-1:0] b, logic [MaskW-1:0] w,
                                 bit typed = 1'b0, logic hit = 1'b0,
                                 logic [CountW-1:0] cnt = '0);
    stim_row_t row;
    row.is_cfg   = 1'b0;
    row.reg_idx  = CFG_PATTERN_LENGTH;
    row.reg_data = '0;
    row.op       = op;
    row.b        = b;
    row.w        = w;
    row.typed    = typed;
    row.hit      = hit;
    row.cnt      = cnt;
    dir_q.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    stim_row_t row;
    row.is_cfg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    row.op       = OP_NOP;
    row.b        = '0;
    row.w        = '0;
    row.typed    = 1'b0;
    row.hit      = 1'b0;
    row.cnt      = '0;
    dir_q.push_back(row);
  endfunction

  initial begin : stimulus
    int unsigned         m;
    int unsigned         sent;
    int unsigned         pick;
    int unsigned         lpos;
    logic [ByteW-1:0]    alpha [AlphaSize];
    logic [1:0]          pat [WordBits];
    logic [MaskW-1:0]    bits;
    logic [CfgDataW-1:0] len;
    bit                  dup;
    bit                  held;
    stim_row_t           row;

    hold_gen         = 0;
    send_idle_pct    = 20;
    recv_idle_pct    = 80;
    gen_len          = LenReset;
    gen_rev          = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mode       = OP_NOP;
    in_if.byte_value = '0;
    in_if.mask_word  = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_PATTERN_LENGTH;
    cfg_data_i       = '0;

    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset state, extreme fields, unused mode, length one forward
    add_op(OP_NOP,     8'h00, 32'h0000_0000, 1, 1'b0, 0);
    add_op(OP_RESTART, 8'h00, 32'h0000_0000, 1, 1'b0, 0);
    add_op(OP_LOAD,    8'h00, 32'h0000_0000, 1, 1'b0, 0);
    add_op(OP_LOAD,    8'hFF, 32'hFFFF_FFFF, 1, 1'b0, 0);
    add_op(OP_SCAN,    8'h00, 32'h0000_0000, 1, 1'b1, 1);
    add_op(OP_SCAN,    8'hFF, 32'h0000_0000, 1, 1'b0, 2);
    add_op(OP_NOP,     8'hFF, 32'hFFFF_FFFF, 1, 1'b0, 2);
    add_op(OP_LOAD,    8'hA5, 32'hFFFF_FFFE, 1, 1'b0, 2);
    add_op(OP_LOAD,    8'h5A, 32'hFFFF_FFFD, 1, 1'b0, 2);
    // Two-byte pattern forward
    add_cfg(CFG_PATTERN_LENGTH, 6'd2);
    add_op(OP_RESTART, 8'h00, 32'h0000_0000, 1, 1'b0, 0);
    add_op(OP_SCAN,    8'hA5, 32'h0000_0000);
    add_op(OP_SCAN,    8'h5A, 32'h0000_0000);
    add_op(OP_SCAN,    8'hA5, 32'h0000_0000);
    // Length out of range on both sides, changed mid-scan without restart
    add_cfg(CFG_PATTERN_LENGTH, 6'd0);
    add_op(OP_SCAN,    8'hA5, 32'h0000_0000);
    add_cfg(CFG_PATTERN_LENGTH, 6'd63);
    add_op(OP_SCAN,    8'h00, 32'h0000_0000);
    add_op(OP_SCAN,    8'hFF, 32'h0000_0000);
    add_cfg(CFG_PATTERN_LENGTH, 6'd32);
    add_op(OP_RESTART, 8'h00, 32'h0000_0000, 1, 1'b0, 0);
    add_op(OP_SCAN,    8'h00, 32'h0000_0000);
    // Reverse order: restart keeps only the low bits, text arrives last byte first
    add_cfg(CFG_REVERSE_SCAN, 6'd1);
    add_cfg(CFG_PATTERN_LENGTH, 6'd2);
    add_op(OP_RESTART, 8'h00, 32'h0000_0000, 1, 1'b0, 0);
    add_op(OP_LOAD,    8'hA5, 32'h0000_0002, 1, 1'b0, 0);
    add_op(OP_LOAD,    8'h5A, 32'h0000_0001, 1, 1'b0, 0);
    add_op(OP_SCAN,    8'h5A, 32'h0000_0000);
    add_op(OP_SCAN,    8'hA5, 32'h0000_0000);
    add_op(OP_NOP,     8'h3C, 32'h1234_5678);

    // Walk the directed table
    foreach (dir_q[i]) begin
      row = dir_q[i];
      if (row.is_cfg) begin
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_item(row.op, row.b, row.w, row.typed, row.hit, row.cnt);
      end
    end

    // Random phases, each with its own setting and pattern
    for (int p = 0; p < NumPhases; p++) begin
      if (p < 2) begin
        send_idle_pct = 20;
        recv_idle_pct = 80;
      end else if (p < 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0:       len = 6'd1;
        1:       len = 6'd32;
        2:       len = 6'd0;
        3:       len = 6'd63;
        default: len = CfgDataW'($urandom_range(63));
      endcase
      write_reg(CFG_PATTERN_LENGTH, len);
      write_reg(CFG_REVERSE_SCAN, CfgDataW'(p % 2));
      m = eff_len(gen_len);

      // Pick a distinct alphabet and a pattern over it
      for (int k = 0; k < AlphaSize; k++) begin
        do begin
          alpha[k] = ByteW'($urandom_range(255));
          dup      = 1'b0;
          for (int j = 0; j < k; j++) begin
            if (alpha[j] == alpha[k]) dup = 1'b1;
          end
        end while (dup);
      end
      for (int l = 0; l < WordBits; l++) pat[l] = 2'($urandom_range(AlphaSize - 1));

      // Load the class masks; reverse order keeps the bits above the pattern clear
      for (int k = 0; k < AlphaSize; k++) begin
        bits = '0;
        for (int l = 0; l < m; l++) begin
          if (pat[l] == k) bits[l] = 1'b1;
        end
        bits = ~bits;
        if (gen_rev) bits = bits & low_ones(m);
        send_item(OP_LOAD, alpha[k], bits);
      end
      send_item(OP_RESTART, ByteW'($urandom_range(255)), $urandom());

      sent = 0;
      held = 1'b0;
      while (sent < PhaseItems) begin
        if (p == PressurePh && !held && sent >= PhaseItems / 2) begin
          hold_gen++;
          held = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 60) begin
          // Whole pattern occurrence in feed order
          for (int j = 0; j < m; j++) begin
            lpos = gen_rev ? (m - 1 - j) : j;
            send_item(OP_SCAN, alpha[pat[lpos]], $urandom());
          end
          sent += m;
        end else begin
          if (pick < 80) begin
            send_item(OP_SCAN, alpha[$urandom_range(AlphaSize - 1)], $urandom());
          end else if (pick < 88) begin
            send_item(OP_LOAD, ByteW'($urandom_range(255)), $urandom());
          end else if (pick < 93) begin
            send_item(OP_SCAN, loaded_q[$urandom_range(loaded_q.size() - 1)], $urandom());
          end else if (pick < 97) begin
            send_item(OP_RESTART, ByteW'($urandom_range(255)), $urandom());
          end else begin
            send_item(OP_NOP, ByteW'($urandom_range(255)), $urandom());
          end
          sent++;
        end
      end
    end

    // Drain and report
    in_if.valid = 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("shift_or_byte_scanner_unit_tb: clean");
    end else begin
      $display("shift_or_byte_scanner_unit_tb: errors");
    end
    $finish;
  end

endmodule
